@@ hw/rtl/bpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the button press classifier: register
// indexes, field widths and the stream payload layouts.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned DurW    = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned InDatW  = 40;
  localparam int unsigned OutDatW = 8;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLED      = 3'd0,
    REG_ACTIVE_LOW   = 3'd1,
    REG_DEBOUNCE     = 3'd2,
    REG_LONG_TIME    = 3'd3,
    REG_MULTI_WINDOW = 3'd4,
    REG_MULTI_TARGET = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic             ack_multi;
    logic             ack_long;
    logic             ack_short;
    logic [TimeW-1:0] now_ms;
    logic             raw_level;
  } tick_t;

  typedef struct packed {
    logic pressed_stable;
    logic multi_pending;
    logic long_pending;
    logic short_pending;
  } report_t;

endpackage : bpc_pkg
`default_nettype wire

@@ hw/rtl/button_press_classifier_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_press_classifier_top
// Debounces a sampled button level and classifies presses into short, long
// and multi-press events that latch until acknowledged.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Transfer when                 Payload
// s_axis    in   s_axis_tvalid & s_axis_tready one tick: level, time, acks
// m_axis    out  m_axis_tvalid & m_axis_tready one report: three flags, state
// cfg       in   cfg_we_i high                 register index and value
//
// A tick transfer loads the tick register; from there it runs through the
// classifier logic into the report register once that register is empty or
// its report is being taken. A new tick is taken every cycle unless a stalled
// report has filled the pipe; the report register and the tick register
// form a two-entry pipe, so a stalled report holds one tick in the tick
// register before s_axis_tready drops. rst_ni clears all flags, timers and
// the pipe and loads the register defaults.
// ----------------------------------------------------------------------------
module button_press_classifier_top
  import bpc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // tick in, from bit 0: raw_level, now_ms[31:0], ack_short, ack_long,
  // ack_multi, zero pad
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [InDatW-1:0]  s_axis_tdata,
  // report out, from bit 0: short_pending, long_pending, multi_pending,
  // pressed_stable, zero pad
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [OutDatW-1:0]      m_axis_tdata,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgDatW-1:0] cfg_wdata_i
);

  // Configuration registers.
  logic              enabled_q, active_low_q;
  logic [DurW-1:0]   debounce_q, long_time_q, window_q;
  logic [CountW-1:0] target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q    <= 1'b1;
      active_low_q <= 1'b1;
      debounce_q   <= DurW'(30);
      long_time_q  <= DurW'(1000);
      window_q     <= DurW'(400);
      target_q     <= CountW'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENABLED:      enabled_q    <= cfg_wdata_i[0];
        REG_ACTIVE_LOW:   active_low_q <= cfg_wdata_i[0];
        REG_DEBOUNCE:     debounce_q   <= cfg_wdata_i;
        REG_LONG_TIME:    long_time_q  <= cfg_wdata_i;
        REG_MULTI_WINDOW: window_q     <= cfg_wdata_i;
        REG_MULTI_TARGET: target_q     <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Pipe control: tick register feeds the report register.
  logic    tick_vld_q, out_vld_q;
  tick_t   tick_q;
  report_t out_q;
  logic    advance;

  assign advance       = tick_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !tick_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (s_axis_tready) tick_vld_q <= s_axis_tvalid;
      if (advance)                        out_vld_q <= 1'b1;
      else if (m_axis_tready)             out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) tick_q <= tick_t'(s_axis_tdata[$bits(tick_t)-1:0]);
  end

  // Classifier state.
  logic              last_raw_q, stable_q, long_fired_q;
  logic              short_flag_q, long_flag_q, multi_flag_q;
  logic [TimeW-1:0]  last_chg_q, press_start_q, first_press_q;
  logic [CountW-1:0] count_q;

  logic              last_raw_d, stable_d, long_fired_d;
  logic              short_flag_d, long_flag_d, multi_flag_d;
  logic [TimeW-1:0]  last_chg_d, press_start_d, first_press_d;
  logic [CountW-1:0] count_d;
  report_t           report;

  logic              pressed, changed, deb_ok, trans, short_ev, multi_ev, long_ev;
  logic              first_now;
  logic [TimeW-1:0]  now, since_chg, since_start, since_first;
  logic [CountW-1:0] count_inc;

  always_comb begin
    now       = tick_q.now_ms;
    pressed   = active_low_q ? !tick_q.raw_level : tick_q.raw_level;
    changed   = pressed != last_raw_q;
    // A fresh level change restarts the debounce timer at zero.
    since_chg = changed ? '0 : now - last_chg_q;
    deb_ok    = since_chg >= TimeW'(debounce_q);
    trans     = deb_ok && (pressed != stable_q);
    short_ev  = trans && !pressed && !long_fired_q;

    // Short press: count it and open the window on the first one.
    first_now   = short_ev && (count_q == '0);
    since_first = first_now ? '0 : now - first_press_q;
    count_inc   = (short_ev && (count_q != CountMax)) ? count_q + CountW'(1) : count_q;
    multi_ev    = short_ev && (since_first <= TimeW'(window_q)) && (count_inc >= target_q);

    // Long press: timer restarts on a new stable press.
    since_start = (trans && pressed) ? '0 : now - press_start_q;

    last_raw_d    = pressed;
    last_chg_d    = changed ? now : last_chg_q;
    stable_d      = trans ? pressed : stable_q;
    press_start_d = (trans && pressed) ? now : press_start_q;
    long_fired_d  = (trans && pressed) ? 1'b0 : long_fired_q;

    long_ev       = stable_d && !long_fired_d && (since_start >= TimeW'(long_time_q));
    if (long_ev) long_fired_d = 1'b1;

    count_d       = count_inc;
    first_press_d = first_now ? now : first_press_q;
    // Drop the count on a multi or long event, or once the window is stale.
    if (multi_ev || long_ev || ((count_inc != '0) && (since_first > TimeW'(window_q)))) begin
      count_d       = '0;
      first_press_d = '0;
    end

    short_flag_d = short_flag_q || short_ev;
    long_flag_d  = long_flag_q || long_ev;
    multi_flag_d = multi_flag_q || multi_ev;

    // Disabled: hold all state, still report and acknowledge.
    if (!enabled_q) begin
      last_raw_d    = last_raw_q;
      last_chg_d    = last_chg_q;
      stable_d      = stable_q;
      press_start_d = press_start_q;
      long_fired_d  = long_fired_q;
      count_d       = count_q;
      first_press_d = first_press_q;
      short_flag_d  = short_flag_q;
      long_flag_d   = long_flag_q;
      multi_flag_d  = multi_flag_q;
    end

    report.short_pending  = short_flag_d;
    report.long_pending   = long_flag_d;
    report.multi_pending  = multi_flag_d;
    report.pressed_stable = stable_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q    <= 1'b0;
      stable_q      <= 1'b0;
      long_fired_q  <= 1'b0;
      short_flag_q  <= 1'b0;
      long_flag_q   <= 1'b0;
      multi_flag_q  <= 1'b0;
      last_chg_q    <= '0;
      press_start_q <= '0;
      first_press_q <= '0;
      count_q       <= '0;
    end else if (advance) begin
      last_raw_q    <= last_raw_d;
      stable_q      <= stable_d;
      long_fired_q  <= long_fired_d;
      short_flag_q  <= short_flag_d && !tick_q.ack_short;
      long_flag_q   <= long_flag_d && !tick_q.ack_long;
      multi_flag_q  <= multi_flag_d && !tick_q.ack_multi;
      last_chg_q    <= last_chg_d;
      press_start_q <= press_start_d;
      first_press_q <= first_press_d;
      count_q       <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= report;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDatW-$bits(report_t)){1'b0}}, out_q};

endmodule : button_press_classifier_top
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for button_press_classifier_top. A scoreboard class
// tracks its own copy of the debounce and press classification state, works
// out the report that every accepted tick must produce and compares each
// report transfer against the oldest pending one. Stimulus is a short
// directed run followed by phases of randomized press/release sequences
// under several register settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import bpc_pkg::*;

  // Register indexes past the last defined register; writes must be ignored.
  localparam logic [CfgIdxW-1:0] SpareRegLo = 3'd6;
  localparam logic [CfgIdxW-1:0] SpareRegHi = 3'd7;

  // Cycles without any transfer or register write before the run is aborted.
  localparam int StallLimit = 4000;

  // --------------------------------------------------------------------------
  // Press state tracker and report checker
  // --------------------------------------------------------------------------
  class press_scoreboard;
    bit            en, act_low;
    bit [DurW-1:0] deb, lng, win;
    bit [CountW-1:0] tgt;

    bit               last_raw, stable, long_fired;
    bit               f_short, f_long, f_multi;
    bit [TimeW-1:0]   t_change, t_press, t_first;
    bit [CountW-1:0]  cnt;

    report_t due[$];
    int      errors;

    function new();
      en      = 1'b1;
      act_low = 1'b1;
      deb     = 16'd30;
      lng     = 16'd1000;
      win     = 16'd400;
      tgt     = 8'd2;
      errors  = 0;
    endfunction

    function bit [TimeW-1:0] ms_since(bit [TimeW-1:0] now, bit [TimeW-1:0] from);
      return now - from;
    endfunction

    function void clear_count();
      cnt     = '0;
      t_first = '0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
      case (idx)
        REG_ENABLED:      en      = val[0];
        REG_ACTIVE_LOW:   act_low = val[0];
        REG_DEBOUNCE:     deb     = val[DurW-1:0];
        REG_LONG_TIME:    lng     = val[DurW-1:0];
        REG_MULTI_WINDOW: win     = val[DurW-1:0];
        REG_MULTI_TARGET: tgt     = val[CountW-1:0];
        default: ;
      endcase
    endfunction

    // Advance the press state by one accepted tick and queue its report.
    function void note_tick(tick_t t);
      bit             pressed;
      bit [TimeW-1:0] now;
      report_t        r;
      if (en) begin
        now     = t.now_ms;
        pressed = t.raw_level ^ act_low;
        if (pressed != last_raw) begin
          last_raw = pressed;
          t_change = now;
        end
        if (ms_since(now, t_change) >= deb && pressed != stable) begin
          stable = pressed;
          if (stable) begin
            t_press    = now;
            long_fired = 1'b0;
          end else if (!long_fired) begin
            f_short = 1'b1;
            if (cnt == 0) t_first = now;
            if (cnt != CountMax) cnt++;
            if (ms_since(now, t_first) <= win && cnt >= tgt) begin
              f_multi = 1'b1;
              clear_count();
            end
          end
        end
        if (stable && !long_fired && ms_since(now, t_press) >= lng) begin
          long_fired = 1'b1;
          f_long     = 1'b1;
          clear_count();
        end
        if (cnt != 0 && ms_since(now, t_first) > win) clear_count();
      end
      r.short_pending  = f_short;
      r.long_pending   = f_long;
      r.multi_pending  = f_multi;
      r.pressed_stable = stable;
      due.push_back(r);
      if (t.ack_short) f_short = 1'b0;
      if (t.ack_long)  f_long  = 1'b0;
      if (t.ack_multi) f_multi = 1'b0;
    endfunction

    function void check_report(report_t got);
      report_t want;
      string   label;
      if (due.size() == 0) begin
        $display("%0t unexpected report: expected none actual %b", $time, got);
        errors++;
        return;
      end
      want = due.pop_front();
      for (int i = 0; i < $bits(report_t); i++) begin
        if (want[i] !== got[i]) begin
          case (i)
            0:       label = "short_pending";
            1:       label = "long_pending";
            2:       label = "multi_pending";
            default: label = "pressed_stable";
          endcase
          $display("%0t %s mismatch: expected %b actual %b", $time, label, want[i], got[i]);
          errors++;
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [InDatW-1:0]  s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OutDatW-1:0] m_axis_tdata;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [CfgDatW-1:0] cfg_wdata_i   = '0;

  press_scoreboard sb = new();

  bit             tx_idle_en = 1'b1;  // random gaps between input transfers
  bit             rx_idle_en = 1'b1;  // random receiver stalls
  bit             hold_req   = 1'b0;  // ask the receiver for one long hold-off
  logic [TimeW-1:0] t_ms     = '0;    // running millisecond clock of the stimulus
  int             ticks_sent = 0;

  button_press_classifier_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Monitors: every input transfer queues a report, every output transfer
  // is checked. Noting comes first so the order within one edge is fixed.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_tick(tick_t'(s_axis_tdata[$bits(tick_t)-1:0]));
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_report(report_t'(m_axis_tdata[$bits(report_t)-1:0]));
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // two-entry pipe fills and the block drops s_axis_tready.
  initial begin : report_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = 80;
      end else if (stall == 0 && rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 8);
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: abort when nothing moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Each acknowledge bit set about one time in four so flags stay latched.
  function automatic logic [2:0] rand_acks();
    return {$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0};
  endfunction

  // Offer one tick and hold it until the transfer; acks are {multi, long, short}.
  // Returns at the transfer edge with tvalid still high unless a gap follows.
  task automatic send_tick(input logic raw, input logic [TimeW-1:0] now,
                           input logic [2:0] acks);
    tick_t t;
    t.raw_level = raw;
    t.now_ms    = now;
    t.ack_short = acks[0];
    t.ack_long  = acks[1];
    t.ack_multi = acks[2];
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDatW - $bits(tick_t)){1'b0}}, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ticks_sent++;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Hold one debounced level (pressed or not) for dur ms spread over 2..5 ticks.
  task automatic hold_level(input bit pressed, input logic [TimeW-1:0] dur);
    int             n;
    logic [TimeW-1:0] step, start;
    n     = $urandom_range(2, 5);
    step  = dur / (n - 1);
    start = t_ms;
    for (int k = 0; k < n; k++) begin
      t_ms = (k == n - 1) ? start + dur : start + step * 32'(k);
      send_tick(pressed ^ sb.act_low, t_ms, rand_acks());
    end
    t_ms = t_ms + 32'($urandom_range(1, 4));
  endtask

  // One press and release, timed against the current register settings:
  // mostly short presses, some long ones, bounces, glitches and noise.
  task automatic press_cycle();
    logic [TimeW-1:0] deb, lng, win, span, p, r;
    deb  = sb.deb;
    lng  = sb.lng;
    win  = sb.win;
    span = (lng == 0) ? 0 : ((lng - 1 < 200) ? lng - 1 : 200);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: p = deb + $urandom_range(0, span);
      6, 7:             p = deb + lng + $urandom_range(0, lng / 2 + 10);
      8:                p = (deb == 0) ? 0 : $urandom_range(0, deb - 1);
      default:          p = $urandom_range(0, 2 * (deb + lng) + 20);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: r = deb + $urandom_range(0, (win < 150) ? win : 150);
      7, 8:                r = deb + $urandom_range(0, 2 * win + 2);
      default:             r = (deb == 0) ? 0 : $urandom_range(0, deb - 1);
    endcase
    if ($urandom_range(0, 7) == 0) begin
      // Drop a one-tick release glitch into the middle of the press.
      hold_level(1'b1, p / 2);
      send_tick(sb.act_low, t_ms, rand_acks());
      t_ms = t_ms + 1;
      hold_level(1'b1, p - p / 2);
    end else begin
      hold_level(1'b1, p);
    end
    hold_level(1'b0, r);
    if ($urandom_range(0, 11) == 0) begin
      // Noise: random levels at random times, the clock jumps with them.
      repeat ($urandom_range(1, 3)) begin
        t_ms = $urandom;
        send_tick(1'($urandom), t_ms, rand_acks());
      end
      t_ms = t_ms + 1;
    end
  endtask

  task automatic run_phase(input int n_ticks);
    ticks_sent = 0;
    while (ticks_sent < n_ticks) press_cycle();
  endtask

  // Stop offering, wait for every pending report, then let the pipe settle.
  task automatic drain();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // Write all six registers; unused upper data bits carry junk to be masked.
  task automatic configure(input bit en, input bit al, input logic [DurW-1:0] deb,
                           input logic [DurW-1:0] lng, input logic [DurW-1:0] win,
                           input logic [CountW-1:0] tgt);
    write_reg(REG_ENABLED,      {15'($urandom), en});
    write_reg(REG_ACTIVE_LOW,   {15'($urandom), al});
    write_reg(REG_DEBOUNCE,     deb);
    write_reg(REG_LONG_TIME,    lng);
    write_reg(REG_MULTI_WINDOW, win);
    write_reg(REG_MULTI_TARGET, {8'($urandom), tgt});
    cfg_we_i <= 1'b0;
  endtask

  // Directed run under the reset settings (active low, 30/1000/400, target 2).
  task automatic directed_run();
    send_tick(1'b1, 32'd0,    3'b000);  // released, idle high
    send_tick(1'b0, 32'd10,   3'b000);  // press edge
    send_tick(1'b0, 32'd39,   3'b000);  // one ms short of the debounce time
    send_tick(1'b0, 32'd40,   3'b000);  // press accepted
    send_tick(1'b1, 32'd100,  3'b000);
    send_tick(1'b1, 32'd130,  3'b000);  // short press, first of the window
    send_tick(1'b0, 32'd200,  3'b111);  // acknowledge everything
    send_tick(1'b0, 32'd230,  3'b000);
    send_tick(1'b1, 32'd300,  3'b000);
    send_tick(1'b1, 32'd330,  3'b000);  // second short press: multi event
    send_tick(1'b0, 32'd400,  3'b000);
    send_tick(1'b0, 32'd430,  3'b000);
    send_tick(1'b0, 32'd1429, 3'b000);  // just under the long press time
    send_tick(1'b0, 32'd1430, 3'b010);  // long press fires, then acknowledged
    send_tick(1'b1, 32'd1500, 3'b000);
    send_tick(1'b1, 32'd1530, 3'b000);  // release after long: no short event
    send_tick(1'b1, 32'd1600, 3'b101);
    send_tick(1'b0, 32'd1700, 3'b000);
    send_tick(1'b0, 32'd1730, 3'b000);
    send_tick(1'b1, 32'd1800, 3'b000);
    send_tick(1'b1, 32'd1830, 3'b000);  // short press opens a new window
    send_tick(1'b1, 32'd2231, 3'b000);  // window gone stale: count cleared
    send_tick(1'b0, 32'hFFFF_FFF0, 3'b000);
    send_tick(1'b0, 32'h0000_000E, 3'b000);  // debounce across the time wrap
    send_tick(1'b1, 32'h0000_0020, 3'b000);
    send_tick(1'b1, 32'h0000_003E, 3'b111);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    // Hold reset from the start, then release it once for the whole run.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_run();
    drain();

    // Reset settings, clock started near the wrap point.
    t_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
    run_phase(250);
    drain();

    // Everything at zero: instant debounce, instant long press, zero target.
    configure(1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 8'd0);
    run_phase(150);
    drain();

    // Everything at its maximum.
    configure(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    t_ms = $urandom;
    run_phase(150);
    drain();

    // Active high with a zero target: every short press in the window is multi.
    configure(1'b1, 1'b0, 16'd5, 16'd300, 16'd1000, 8'd0);
    run_phase(250);
    drain();

    // Disable the block; ticks must leave the state alone while acks still
    // clear flags. Writes to the spare indexes must change nothing.
    write_reg(REG_ENABLED, {15'($urandom), 1'b0});
    write_reg(SpareRegLo, 16'($urandom));
    write_reg(SpareRegHi, 16'($urandom));
    cfg_we_i <= 1'b0;
    run_phase(40);
    drain();

    // Random settings; hold off the receiver midway while ticks keep coming.
    configure(1'b1, 1'($urandom), 16'($urandom_range(0, 60)), 16'($urandom_range(50, 2000)),
              16'($urandom_range(50, 1500)), 8'($urandom_range(1, 6)));
    t_ms = $urandom;
    run_phase(120);
    hold_req = 1'b1;
    run_phase(130);
    drain();

    configure(1'b1, 1'($urandom), 16'($urandom_range(0, 60)), 16'($urandom_range(50, 2000)),
              16'($urandom_range(50, 1500)), 8'($urandom_range(1, 6)));
    run_phase(250);
    drain();

    // Last stretch at full rate on both sides.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    configure(1'b1, 1'b1, 16'd20, 16'd500, 16'd600, 8'd3);
    run_phase(200);
    drain();

    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
